// ----- hdl/y86e_pkg.sv -----
// ----------------------------------------------------------------------------
// y86e_pkg
// Shared codes and helper functions for the Y86-64 instruction executor.
// ----------------------------------------------------------------------------
package y86e_pkg;

  localparam int unsigned DataMemBytes = 4096;

  localparam logic [3:0] NoReg    = 4'hf;
  localparam logic [3:0] StackReg = 4'h4;

  // opcodes
  localparam logic [3:0] OpHalt  = 4'h0;
  localparam logic [3:0] OpNop   = 4'h1;
  localparam logic [3:0] OpMove  = 4'h2;
  localparam logic [3:0] OpIrmov = 4'h3;
  localparam logic [3:0] OpRmmov = 4'h4;
  localparam logic [3:0] OpMrmov = 4'h5;
  localparam logic [3:0] OpAlu   = 4'h6;
  localparam logic [3:0] OpJump  = 4'h7;
  localparam logic [3:0] OpCall  = 4'h8;
  localparam logic [3:0] OpRet   = 4'h9;
  localparam logic [3:0] OpPush  = 4'ha;
  localparam logic [3:0] OpPop   = 4'hb;
  localparam logic [3:0] OpIadd  = 4'hc;

  // alu functions
  localparam logic [3:0] FnAdd = 4'h0;
  localparam logic [3:0] FnSub = 4'h1;
  localparam logic [3:0] FnAnd = 4'h2;

  // condition functions
  localparam logic [3:0] CcLe = 4'h1;
  localparam logic [3:0] CcL  = 4'h2;
  localparam logic [3:0] CcE  = 4'h3;
  localparam logic [3:0] CcNe = 4'h4;
  localparam logic [3:0] CcGe = 4'h5;
  localparam logic [3:0] CcG  = 4'h6;

  // run status
  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StHlt = 2'd1;
  localparam logic [1:0] StAdr = 2'd2;
  localparam logic [1:0] StIns = 2'd3;

  // legal opcode / function pairs
  function automatic logic ins_valid(input logic [3:0] op, input logic [3:0] fn);
    logic ok;
    if (op == OpMove || op == OpJump) begin
      ok = (fn <= CcG);
    end else if (op == OpAlu) begin
      ok = (fn <= 4'h3);
    end else if (op <= OpIadd) begin
      ok = (fn == 4'h0);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // instruction length in bytes
  function automatic logic [3:0] ins_len(input logic [3:0] op);
    logic [3:0] len;
    case (op)
      OpHalt, OpNop, OpRet:              len = 4'd1;
      OpMove, OpAlu, OpPush, OpPop:      len = 4'd2;
      OpJump, OpCall:                    len = 4'd9;
      default:                           len = 4'd10;
    endcase
    return len;
  endfunction

  // branch / move condition from the current flags
  function automatic logic cond_eval(input logic [3:0] fn, input logic zf,
                                     input logic sf, input logic of);
    logic lt;
    logic c;
    lt = sf ^ of;
    case (fn)
      CcLe:    c = zf | lt;
      CcL:     c = lt;
      CcE:     c = zf;
      CcNe:    c = ~zf;
      CcGe:    c = ~lt;
      CcG:     c = ~lt & ~zf;
      default: c = 1'b1;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/y86e_if.sv -----
// ----------------------------------------------------------------------------
// y86e_if
// Valid/ready channels for decoded instructions and execution results.
// ----------------------------------------------------------------------------
interface y86e_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [3:0]  function_code;
  logic [3:0]  reg_a;
  logic [3:0]  reg_b;
  logic signed [63:0] const_value;

  modport source (output valid, opcode, function_code, reg_a, reg_b, const_value,
                  input ready);
  modport sink   (input valid, opcode, function_code, reg_a, reg_b, const_value,
                  output ready);
endinterface

interface y86e_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;
  logic [1:0]  status;
  logic [3:0]  dest_reg;
  logic signed [63:0] dest_value;
  logic        zero_flag;
  logic        sign_flag;
  logic        overflow_flag;
  logic        cond_taken;

  modport source (output valid, next_pc, status, dest_reg, dest_value, zero_flag,
                  sign_flag, overflow_flag, cond_taken, input ready);
  modport sink   (input valid, next_pc, status, dest_reg, dest_value, zero_flag,
                  sign_flag, overflow_flag, cond_taken, output ready);
endinterface

// ----- hdl/y86e_ram.sv -----
// ----------------------------------------------------------------------------
// y86e_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module y86e_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/y86_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// y86_instruction_executor
// Executes one decoded Y86-64 instruction per transaction against its own
// register file, PC, condition codes, status and byte data memory.
// ----------------------------------------------------------------------------
// An instruction moves from the input register to the result register once
// the result register is free; mrmovq, ret and popq first wait on the load
// phase, as the data memory hands back read data the cycle after the address.
// A new instruction is taken in the cycle the current one completes, so the
// rate is one per cycle while the result is taken and no load is waiting.
// The data memory is eight byte-wide banks, so an unaligned 8-byte access is
// one row per bank. After reset a clearing pass zeroes the memory one row a
// cycle; no instruction is taken until it ends. Once the status leaves ok,
// every instruction reports the held state until reset.
module y86_instruction_executor
  import y86e_pkg::*;
#(
  parameter int unsigned DATA_MEM_BYTES = DataMemBytes
) (
  input  logic clk_i,
  input  logic rst_ni,
  y86e_in_if.sink    item_i,
  y86e_out_if.source result_o
);

  localparam int unsigned Rows  = (DATA_MEM_BYTES + 7) / 8;
  localparam int unsigned RowAw = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [63:0] AddrMax = 64'(DATA_MEM_BYTES - 8);

  // input register
  logic        item_v_q;
  logic        phase_q;
  logic [3:0]  op_q, fn_q, ra_q, rb_q;
  logic [63:0] c_q;

  // architectural state
  logic [63:0] rf_q [15];
  logic [63:0] pc_q;
  logic        zf_q, sf_q, of_q;
  logic [1:0]  st_q;

  // clearing pass
  logic             clr_busy_q;
  logic [RowAw-1:0] clr_row_q;

  // result register
  logic        out_v_q;
  logic [63:0] out_pc_q, out_dval_q;
  logic [1:0]  out_st_q;
  logic [3:0]  out_dreg_q;
  logic        out_zf_q, out_sf_q, out_of_q, out_cnd_q;

  // memory banks
  logic [7:0]       bank_rd [8];
  logic [7:0]       bank_wd [8];
  logic [RowAw-1:0] bank_row [8];

  // execute results
  logic        fin, needs_rd, in_ready;
  logic [63:0] a_val, b_val, sp_val, seq_pc, addr, mem_val, alu_r, alu_x;
  logic        addr_ok, cnd, alu_of;
  logic [63:0] npc, dval, wval, sp_new, mem_wdata;
  logic [3:0]  dreg, wid;
  logic [1:0]  st_new;
  logic        reg_wr, sp_wr, flags_wr, mem_we;

  // operand reads
  always_comb begin
    a_val  = (ra_q == NoReg) ? 64'd0 : rf_q[ra_q];
    b_val  = (rb_q == NoReg) ? 64'd0 : rf_q[rb_q];
    sp_val = rf_q[StackReg];
    seq_pc = pc_q + 64'(ins_len(op_q));
    cnd    = cond_eval(fn_q, zf_q, sf_q, of_q);
  end

  // effective address and range check
  always_comb begin
    case (op_q)
      OpCall, OpPush: addr = sp_val - 64'd8;
      OpRet, OpPop:   addr = sp_val;
      default:        addr = b_val + c_q;
    endcase
    addr_ok = (addr <= AddrMax);
  end

  // alu for OPq and iaddq
  always_comb begin
    logic [3:0] f;
    f      = (op_q == OpIadd) ? FnAdd : fn_q;
    alu_x  = (op_q == OpIadd) ? c_q : a_val;
    alu_of = 1'b0;
    case (f)
      FnAdd: begin
        alu_r  = b_val + alu_x;
        alu_of = ~(b_val[63] ^ alu_x[63]) & (b_val[63] ^ alu_r[63]);
      end
      FnSub: begin
        alu_r  = b_val - alu_x;
        alu_of = (b_val[63] ^ alu_x[63]) & (b_val[63] ^ alu_r[63]);
      end
      FnAnd:   alu_r = b_val & alu_x;
      default: alu_r = b_val ^ alu_x;
    endcase
  end

  // gather the 8 read bytes, little endian
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mem_val[8*i +: 8] = bank_rd[3'(addr[2:0] + 3'(i))];
    end
  end

  // instruction execution
  always_comb begin
    npc       = seq_pc;
    st_new    = st_q;
    dreg      = NoReg;
    dval      = 64'd0;
    wid       = NoReg;
    wval      = 64'd0;
    reg_wr    = 1'b0;
    sp_wr     = 1'b0;
    sp_new    = 64'd0;
    flags_wr  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = a_val;
    needs_rd  = 1'b0;
    if (st_q != StOk) begin
      npc = pc_q;
    end else if (!ins_valid(op_q, fn_q)) begin
      st_new = StIns;
      npc    = pc_q;
    end else if (op_q == OpHalt) begin
      st_new = StHlt;
      npc    = pc_q;
    end else begin
      case (op_q)
        OpMove: begin
          reg_wr = cnd;
          wid    = rb_q;
          wval   = a_val;
        end
        OpIrmov: begin
          reg_wr = 1'b1;
          wid    = rb_q;
          wval   = c_q;
        end
        OpRmmov: begin
          mem_we = addr_ok;
        end
        OpMrmov: begin
          needs_rd = addr_ok;
          reg_wr   = addr_ok;
          wid      = ra_q;
          wval     = mem_val;
        end
        OpAlu, OpIadd: begin
          flags_wr = 1'b1;
          reg_wr   = 1'b1;
          wid      = rb_q;
          wval     = alu_r;
        end
        OpJump: begin
          if (cnd) begin
            npc = c_q;
          end
        end
        OpCall: begin
          mem_we    = addr_ok;
          mem_wdata = seq_pc;
          sp_wr     = addr_ok;
          sp_new    = addr;
          npc       = c_q;
        end
        OpRet: begin
          needs_rd = addr_ok;
          sp_wr    = addr_ok;
          sp_new   = sp_val + 64'd8;
          npc      = mem_val;
        end
        OpPush: begin
          mem_we = addr_ok;
          sp_wr  = addr_ok;
          sp_new = addr;
        end
        OpPop: begin
          needs_rd = addr_ok;
          sp_wr    = addr_ok;
          sp_new   = sp_val + 64'd8;
          reg_wr   = addr_ok;
          wid      = ra_q;
          wval     = mem_val;
        end
        default: ;
      endcase
      if (sp_wr) begin
        dreg = StackReg;
        dval = sp_new;
      end
      if (reg_wr && wid != NoReg) begin
        dreg = wid;
        dval = wval;
      end
      if ((op_q == OpRmmov || op_q == OpMrmov || op_q == OpCall || op_q == OpRet ||
           op_q == OpPush || op_q == OpPop) && !addr_ok) begin
        st_new = StAdr;
        npc    = pc_q;
      end
    end
  end

  // handshake
  assign fin      = item_v_q && (!needs_rd || phase_q) && (!out_v_q || result_o.ready);
  assign in_ready = !clr_busy_q && (!item_v_q || fin);
  assign item_i.ready = in_ready;

  // input register and load phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      phase_q  <= 1'b0;
    end else begin
      if (in_ready && item_i.valid) begin
        item_v_q <= 1'b1;
      end else if (fin) begin
        item_v_q <= 1'b0;
      end
      if (fin) begin
        phase_q <= 1'b0;
      end else if (item_v_q && needs_rd) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      op_q <= item_i.opcode;
      fn_q <= item_i.function_code;
      ra_q <= item_i.reg_a;
      rb_q <= item_i.reg_b;
      c_q  <= item_i.const_value;
    end
  end

  // architectural state update; the explicit destination wins over rsp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 15; i++) begin
        rf_q[i] <= 64'd0;
      end
      pc_q <= 64'd0;
      zf_q <= 1'b1;
      sf_q <= 1'b0;
      of_q <= 1'b0;
      st_q <= StOk;
    end else if (fin) begin
      if (sp_wr && !(reg_wr && wid == StackReg)) begin
        rf_q[StackReg] <= sp_new;
      end
      if (reg_wr && wid != NoReg) begin
        rf_q[wid] <= wval;
      end
      if (flags_wr) begin
        zf_q <= (alu_r == 64'd0);
        sf_q <= alu_r[63];
        of_q <= alu_of;
      end
      st_q <= st_new;
      if (st_q == StOk) begin
        pc_q <= npc;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_pc_q   <= npc;
      out_st_q   <= st_new;
      out_dreg_q <= dreg;
      out_dval_q <= dval;
      out_zf_q   <= flags_wr ? (alu_r == 64'd0) : zf_q;
      out_sf_q   <= flags_wr ? alu_r[63] : sf_q;
      out_of_q   <= flags_wr ? alu_of : of_q;
      out_cnd_q  <= (st_q == StOk) && (st_new == StOk) &&
                    (op_q == OpMove || op_q == OpJump) && cnd;
    end
  end

  assign result_o.valid         = out_v_q;
  assign result_o.next_pc       = out_pc_q;
  assign result_o.status        = out_st_q;
  assign result_o.dest_reg      = out_dreg_q;
  assign result_o.dest_value    = out_dval_q;
  assign result_o.zero_flag     = out_zf_q;
  assign result_o.sign_flag     = out_sf_q;
  assign result_o.overflow_flag = out_of_q;
  assign result_o.cond_taken    = out_cnd_q;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_row_q == RowAw'(Rows - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_row_q <= clr_row_q + 1'b1;
      end
    end
  end

  // byte banks: bank l holds bytes whose address is l modulo 8
  for (genvar l = 0; l < 8; l++) begin : g_bank
    logic [2:0] idx;
    assign idx          = 3'(3'(l) - addr[2:0]);
    assign bank_row[l]  = addr[RowAw+2:3] + RowAw'(3'(l) < addr[2:0]);
    assign bank_wd[l]   = mem_wdata[8*idx +: 8];

    y86e_ram #(
      .Width (8),
      .Depth (Rows)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (clr_busy_q || (fin && mem_we)),
      .waddr_i (clr_busy_q ? clr_row_q : bank_row[l]),
      .wdata_i (clr_busy_q ? 8'd0 : bank_wd[l]),
      .raddr_i (bank_row[l]),
      .rdata_o (bank_rd[l])
    );
  end

endmodule

// ----- hdl/y86e_checker.sv -----
// ----------------------------------------------------------------------------
// y86e_checker
// Port-level checks on the executor's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module y86e_checker
  import y86e_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_status,
  input logic [3:0]  res_dest_reg,
  input logic [63:0] res_dest_value,
  input logic        res_cond_taken
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !res_valid)
    else $error("result valid during reset");

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn before transaction");

  // no register written means a zero value
  a_no_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_dest_reg == NoReg |-> res_dest_value == 64'd0)
    else $error("value reported without destination");

  // a stopped machine writes nothing and takes no condition
  a_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_status != StOk |-> res_dest_reg == NoReg && !res_cond_taken)
    else $error("side effect reported with non-ok status");

endmodule

bind y86_instruction_executor y86e_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid      (result_o.valid),
  .res_ready      (result_o.ready),
  .res_status     (result_o.status),
  .res_dest_reg   (result_o.dest_reg),
  .res_dest_value (result_o.dest_value),
  .res_cond_taken (result_o.cond_taken)
);
